FILE: hw/rtl/ubef_pkg.sv
package ubef_pkg;

  // Descriptor type codes and field codes of the USB descriptor format.
  localparam logic [7:0] DESC_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
  localparam logic [1:0] XFER_BULK      = 2'h2;
  localparam int         EP_DIR_BIT     = 7;

  localparam logic [7:0] MIN_DESC_LEN   = 8'd2;
  localparam logic [7:0] MIN_INTF_LEN   = 8'd9;
  localparam logic [7:0] MIN_EP_LEN     = 8'd7;

  localparam logic [15:0] MPS_DEFAULT   = 16'd64;
  localparam logic [7:0]  INTF_NONE     = 8'hFF;

  // Register reset values and indexes on the configuration port.
  localparam logic [7:0] DATA_CLASS_RESET = 8'd10;
  localparam logic [7:0] COMM_CLASS_RESET = 8'd2;
  localparam logic       REG_DATA_CLASS   = 1'b0;
  localparam logic       REG_COMM_CLASS   = 1'b1;
  localparam int         CFG_ADDR_W       = 3;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  in_endpoint;
    logic [7:0]  out_endpoint;
    logic [15:0] in_max_packet;
    logic [7:0]  data_interface;
    logic [7:0]  comm_interface;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data_class_code;
    logic [7:0] comm_class_code;
  } cfg_regs_t;

endpackage

FILE: hw/rtl/usb_bulk_endpoint_finder.sv
// Walks a USB configuration descriptor set, one byte per transfer, and picks
// the bulk IN and OUT endpoints, preferring those of a CDC data interface.
// A byte is taken into an input register and processed in the next cycle by
// the descriptor walker unless it is a last byte that must wait, so one byte
// is accepted in every cycle while in_stall is low. The result for the last
// byte is put in the output register when the walker processes it, unless an
// earlier result is still waiting there. in_stall is raised only while a last
// byte waits in the input register behind a result not yet taken; the walker
// state returns to its reset value after each result, so the next set may
// follow at once. Class codes are to be set through the register port while
// the block is idle; the user must keep to this, the block does not enforce it.
module usb_bulk_endpoint_finder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ubef_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ubef_pkg::out_item_t              out_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ubef_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ubef_pkg::cfg_regs_t regs;
  ubef_pkg::in_item_t  s_item_r;
  ubef_pkg::out_item_t result;
  ubef_pkg::out_item_t out_item_r;
  logic                s_valid_r;
  logic                out_valid_r;
  logic                fire;
  logic                fire_last;
  logic                in_accept;

  ubef_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  ubef_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (s_item_r),
    .regs   (regs),
    .result (result)
  );

  // A non-last byte never needs the output register, so only a last byte
  // waits for room there.
  assign fire      = s_valid_r && (!s_item_r.last_byte || !out_valid_r || !out_stall);
  assign fire_last = fire && s_item_r.last_byte;
  assign in_stall  = s_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_accept) begin
      s_valid_r <= 1'b1;
    end else if (fire) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s_item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s_valid_r && s_item_r.last_byte && out_valid_r))
    else $error("input stalled without a blocked last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire_last |=> out_valid)
    else $error("last byte processed without a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fire_last)
    else $error("pending result overwritten");

endmodule

FILE: hw/rtl/ubef_cfg.sv
module ubef_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ubef_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output ubef_pkg::cfg_regs_t              regs
);

  logic [7:0] data_class_r;
  logic [7:0] comm_class_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_class_r <= ubef_pkg::DATA_CLASS_RESET;
      comm_class_r <= ubef_pkg::COMM_CLASS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        ubef_pkg::REG_DATA_CLASS: data_class_r <= pwdata[7:0];
        ubef_pkg::REG_COMM_CLASS: comm_class_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ubef_pkg::REG_DATA_CLASS: prdata = {24'd0, data_class_r};
      ubef_pkg::REG_COMM_CLASS: prdata = {24'd0, comm_class_r};
      default:                  prdata = 32'd0;
    endcase
  end

  assign regs.data_class_code = data_class_r;
  assign regs.comm_class_code = comm_class_r;

endmodule

FILE: hw/rtl/ubef_parse.sv
module ubef_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  ubef_pkg::in_item_t   item,
  input  ubef_pkg::cfg_regs_t  regs,
  output ubef_pkg::out_item_t  result
);

  // Byte positions within one descriptor and, for the total length, within the set.
  localparam logic [15:0] OFS_LENGTH = 16'd0;
  localparam logic [15:0] OFS_KIND   = 16'd1;
  localparam logic [15:0] OFS_ADDR   = 16'd2;
  localparam logic [15:0] OFS_ATTR   = 16'd3;
  localparam logic [15:0] OFS_MPS_LO = 16'd4;
  localparam logic [15:0] OFS_COMMIT = 16'd5;
  localparam logic [15:0] TOTAL_LO   = 16'd2;
  localparam logic [15:0] TOTAL_HI   = 16'd3;
  localparam logic [15:0] FIRST_NEXT = 16'd4;

  logic [15:0] offset_r, offset_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] start_r, start_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic        stopped_r, stopped_nxt;
  logic [7:0]  cur_class_r, cur_class_nxt;
  logic [7:0]  cur_intf_r, cur_intf_nxt;
  logic [7:0]  pend_addr_r, pend_addr_nxt;
  logic [7:0]  pend_attr_r, pend_attr_nxt;
  logic [7:0]  mps_lo_r, mps_lo_nxt;
  logic [7:0]  best_in_r, best_in_nxt;
  logic [7:0]  best_out_r, best_out_nxt;
  logic [7:0]  best_intf_r, best_intf_nxt;
  logic [15:0] best_mps_r, best_mps_nxt;
  logic        cdc_taken_r, cdc_taken_nxt;
  logic        comm_seen_valid;
  logic [7:0]  comm_seen_r, comm_seen_nxt;

  logic [15:0] rel;
  logic [7:0]  b;
  logic        in_data;
  logic        stop;
  logic [16:0] desc_end;
  logic [16:0] offset_inc;

  assign b          = item.desc_byte;
  assign rel        = offset_r - start_r;
  assign in_data    = (cur_class_r == regs.data_class_code);
  assign offset_inc = {1'b0, offset_r} + 17'd1;

  always_comb begin
    offset_nxt    = offset_r;
    total_nxt     = total_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    kind_nxt      = kind_r;
    cur_class_nxt = cur_class_r;
    cur_intf_nxt  = cur_intf_r;
    pend_addr_nxt = pend_addr_r;
    pend_attr_nxt = pend_attr_r;
    mps_lo_nxt    = mps_lo_r;
    best_in_nxt   = best_in_r;
    best_out_nxt  = best_out_r;
    best_intf_nxt = best_intf_r;
    best_mps_nxt  = best_mps_r;
    cdc_taken_nxt = cdc_taken_r;
    comm_seen_nxt = comm_seen_r;
    stop          = stopped_r;
    comm_seen_valid = 1'b0;

    if (!stopped_r) begin
      if (offset_r == TOTAL_LO) begin
        total_nxt = {total_r[15:8], b};
      end else if (offset_r == TOTAL_HI) begin
        total_nxt = {b, total_r[7:0]};
      end

      case (rel)
        OFS_LENGTH: begin
          len_nxt = b;
          if (b < ubef_pkg::MIN_DESC_LEN) stop = 1'b1;
        end
        OFS_KIND:   kind_nxt      = b;
        OFS_ADDR:   pend_addr_nxt = b;
        OFS_ATTR:   pend_attr_nxt = b;
        OFS_MPS_LO: mps_lo_nxt    = b;
        OFS_COMMIT: begin
          if (kind_r == ubef_pkg::DESC_INTERFACE && len_r >= ubef_pkg::MIN_INTF_LEN) begin
            cur_intf_nxt  = pend_addr_r;
            cur_class_nxt = b;
            if (b == regs.comm_class_code) begin
              comm_seen_nxt   = pend_addr_r;
              comm_seen_valid = 1'b1;
            end
          end
          if (kind_r == ubef_pkg::DESC_ENDPOINT && len_r >= ubef_pkg::MIN_EP_LEN &&
              pend_attr_r[1:0] == ubef_pkg::XFER_BULK && (in_data || !cdc_taken_r)) begin
            if (pend_addr_r[ubef_pkg::EP_DIR_BIT]) begin
              best_in_nxt  = pend_addr_r;
              best_mps_nxt = {b, mps_lo_r};
            end else begin
              best_out_nxt = pend_addr_r;
            end
            best_intf_nxt = cur_intf_r;
            if (in_data) cdc_taken_nxt = 1'b1;
          end
        end
        default: ;
      endcase

      // The first descriptor starts before the total is known, so its bounds
      // are checked once the high byte of the total has arrived.
      if (!stop && ((rel == OFS_LENGTH && offset_r >= FIRST_NEXT) || offset_r == TOTAL_HI)) begin
        if (start_r >= total_nxt ||
            ({1'b0, start_r} + {9'd0, len_nxt}) > {1'b0, total_nxt}) begin
          stop = 1'b1;
        end
      end

      if (!stop && rel != OFS_LENGTH && offset_inc == desc_end) begin
        start_nxt = offset_inc[15:0];
      end

      if (!stop) offset_nxt = offset_inc[15:0];
    end
    stopped_nxt = stop;
  end

  assign desc_end = {1'b0, start_r} + {9'd0, len_nxt};

  always_comb begin
    result.found          = (best_in_nxt != 8'd0) && (best_out_nxt != 8'd0);
    result.in_endpoint    = best_in_nxt;
    result.out_endpoint   = best_out_nxt;
    result.in_max_packet  = best_mps_nxt;
    result.data_interface = best_intf_nxt;
    result.comm_interface = comm_seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      offset_r    <= 16'd0;
      total_r     <= 16'd0;
      start_r     <= 16'd0;
      len_r       <= 8'd0;
      kind_r      <= 8'd0;
      stopped_r   <= 1'b0;
      cur_class_r <= 8'd0;
      cur_intf_r  <= 8'd0;
      pend_addr_r <= 8'd0;
      pend_attr_r <= 8'd0;
      mps_lo_r    <= 8'd0;
      best_in_r   <= 8'd0;
      best_out_r  <= 8'd0;
      best_intf_r <= 8'd0;
      best_mps_r  <= ubef_pkg::MPS_DEFAULT;
      cdc_taken_r <= 1'b0;
      comm_seen_r <= ubef_pkg::INTF_NONE;
    end else if (step) begin
      offset_r    <= offset_nxt;
      total_r     <= total_nxt;
      start_r     <= start_nxt;
      len_r       <= len_nxt;
      kind_r      <= kind_nxt;
      stopped_r   <= stopped_nxt;
      cur_class_r <= cur_class_nxt;
      cur_intf_r  <= cur_intf_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_attr_r <= pend_attr_nxt;
      mps_lo_r    <= mps_lo_nxt;
      best_in_r   <= best_in_nxt;
      best_out_r  <= best_out_nxt;
      best_intf_r <= best_intf_nxt;
      best_mps_r  <= best_mps_nxt;
      cdc_taken_r <= cdc_taken_nxt;
      comm_seen_r <= comm_seen_nxt;
    end
  end

  // Once stopped, no byte may move the walk forward.
  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && stopped_r) |-> (offset_nxt == offset_r && start_nxt == start_r))
    else $error("parser advanced after stopping");

  // The comm interface only changes on the commit byte of an interface.
  a_comm_commit: assert property (@(posedge clk) disable iff (!rst_n)
    comm_seen_valid |-> (rel == OFS_COMMIT && kind_r == ubef_pkg::DESC_INTERFACE))
    else $error("comm interface recorded outside an interface commit");

  // A descriptor start never runs ahead of the stream offset.
  a_start_behind: assert property (@(posedge clk) disable iff (!rst_n)
    start_r <= offset_r)
    else $error("descriptor start past stream offset");

endmodule
